// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Types and constants of the sorted sleep/wakeup queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int IdWidthDef    = 8;

  localparam int TickW   = 64;
  localparam int DurW    = 32;
  localparam int IdPortW = 8;
  localparam int KindW   = 2;

  typedef enum logic [KindW-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_WAKE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLP_START,
    ST_SLP_RD,
    ST_SLP_CMP,
    ST_SLP_WR,
    ST_TCK_RD,
    ST_TCK_CMP,
    ST_TCK_FLUSH
  } state_e;

  typedef struct packed {
    logic ld_sleep;
    logic ld_tick;
    logic rd_ptr;
    logic rd_head;
    logic mv;
    logic ins;
    logic emit_acc;
    logic emit_rej;
    logic pop;
    logic emit_pend;
    logic pend_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rem_one;
    logic rd_gt_new;
    logic rd_due;
    logic pend_v;
    logic count_one;
  } ctrl_sts_t;

endpackage

// File: hw/rtl/ssq_ctrl.sv
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer for insert walks and tick pops of the sleeper queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      action_i,
  output logic      busy_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_SLEEP) begin
            cmd_o.ld_sleep = 1'b1;
            state_d        = ST_SLP_START;
          end else begin
            cmd_o.ld_tick = 1'b1;
            if (!sts_i.empty) state_d = ST_TCK_RD;
          end
        end
      end
      ST_SLP_START: begin
        if (sts_i.full) begin
          cmd_o.emit_rej = 1'b1;
          state_d        = ST_IDLE;
        end else if (sts_i.empty) begin
          cmd_o.ins      = 1'b1;
          cmd_o.emit_acc = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_SLP_RD;
        end
      end
      ST_SLP_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = ST_SLP_CMP;
      end
      ST_SLP_CMP: begin
        if (sts_i.rd_gt_new) begin
          cmd_o.mv = 1'b1;
          state_d  = sts_i.rem_one ? ST_SLP_WR : ST_SLP_RD;
        end else begin
          cmd_o.ins      = 1'b1;
          cmd_o.emit_acc = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SLP_WR: begin
        cmd_o.ins      = 1'b1;
        cmd_o.emit_acc = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_TCK_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = ST_TCK_CMP;
      end
      ST_TCK_CMP: begin
        if (sts_i.rd_due) begin
          cmd_o.emit_pend = sts_i.pend_v;
          cmd_o.pop       = 1'b1;
          state_d         = sts_i.count_one ? ST_TCK_FLUSH : ST_TCK_RD;
        end else begin
          cmd_o.emit_pend = sts_i.pend_v;
          cmd_o.pend_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_TCK_FLUSH: begin
        cmd_o.emit_pend = 1'b1;
        cmd_o.pend_last = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  `ASSERT_IMP(a_pend_emit, cmd_o.emit_pend, sts_i.pend_v)

endmodule

// File: hw/rtl/ssq_datapath.sv
// ----------------------------------------------------------------------------
// ssq_datapath
// Tick counter, circular entry memory, walk pointer and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssq_datapath
  import ssq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_WIDTH    = IdWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_sts_t          sts_o,
  input  logic [IdPortW-1:0] sleeper_id_i,
  input  logic [DurW-1:0]    duration_i,
  output logic               res_valid_o,
  output logic [KindW-1:0]   kind_o,
  output logic [IdPortW-1:0] sleeper_id_res_o,
  output logic [TickW-1:0]   wake_tick_o,
  output logic               last_o
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int IdW  = (ID_WIDTH < IdPortW) ? ID_WIDTH : IdPortW;
  localparam int EntW = TickW + IdW;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [EntW-1:0]  mem_q [QUEUE_DEPTH];
  logic [EntW-1:0]  rd_q;
  logic [TickW-1:0] tick_q;
  logic [PW-1:0]    head_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    rem_q;
  logic [PW-1:0]    ptr_q;
  logic [TickW-1:0] new_wake_q;
  logic [IdW-1:0]   new_id_q;
  logic [EntW-1:0]  pend_q;
  logic             pend_v_q;
  logic             res_valid_q;
  logic [KindW-1:0] kind_q;
  logic [IdW-1:0]   res_id_q;
  logic [TickW-1:0] res_wake_q;
  logic             last_q;

  logic [SW-1:0]    tail_sum;
  logic [PW-1:0]    tail_m1;
  logic [PW-1:0]    rd_addr;
  logic [TickW-1:0] rd_wake;
  logic [IdPortW-1:0] id_ext;

  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(QUEUE_DEPTH)) tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    tail_m1 = ptr_dec(tail_sum[PW-1:0]);
  end

  assign rd_addr = cmd_i.rd_head ? head_q : ptr_q;
  assign rd_wake = rd_q[EntW-1:IdW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mv) begin
      mem_q[ptr_inc(ptr_q)] <= rd_q;
    end else if (cmd_i.ins) begin
      mem_q[ptr_inc(ptr_q)] <= {new_wake_q, new_id_q};
    end
    if (cmd_i.rd_ptr || cmd_i.rd_head) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      head_q   <= '0;
      count_q  <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.ld_tick) tick_q <= tick_q + 1'b1;
      if (cmd_i.ins) count_q <= count_q + 1'b1;
      if (cmd_i.pop) begin
        head_q  <= ptr_inc(head_q);
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.pop) pend_v_q <= 1'b1;
      else if (cmd_i.emit_pend) pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sleep) begin
      new_wake_q <= tick_q + TickW'(duration_i);
      new_id_q   <= sleeper_id_i[IdW-1:0];
      ptr_q      <= tail_m1;
      rem_q      <= count_q;
    end
    if (cmd_i.mv) begin
      ptr_q <= ptr_dec(ptr_q);
      rem_q <= rem_q - 1'b1;
    end
    if (cmd_i.pop) pend_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_acc || cmd_i.emit_rej || cmd_i.emit_pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_acc || cmd_i.emit_rej) begin
      kind_q     <= cmd_i.emit_rej ? KIND_REJECT : KIND_ACCEPT;
      res_id_q   <= new_id_q;
      res_wake_q <= new_wake_q;
      last_q     <= 1'b1;
    end else if (cmd_i.emit_pend) begin
      kind_q     <= KIND_WAKE;
      res_id_q   <= pend_q[IdW-1:0];
      res_wake_q <= pend_q[EntW-1:IdW];
      last_q     <= cmd_i.pend_last;
    end
  end

  always_comb begin
    id_ext          = '0;
    id_ext[IdW-1:0] = res_id_q;
  end

  assign sts_o.full      = (count_q == CW'(QUEUE_DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.count_one = (count_q == CW'(1));
  assign sts_o.rem_one   = (rem_q == CW'(1));
  assign sts_o.rd_gt_new = (rd_wake > new_wake_q);
  assign sts_o.rd_due    = (rd_wake <= tick_q);
  assign sts_o.pend_v    = pend_v_q;

  assign res_valid_o      = res_valid_q;
  assign kind_o           = kind_q;
  assign sleeper_id_res_o = id_ext;
  assign wake_tick_o      = res_wake_q;
  assign last_o           = last_q;

  `ASSERT_IMP(a_pop_nonempty, cmd_i.pop, count_q != '0)
  `ASSERT_IMP(a_ins_not_full, cmd_i.ins, count_q < CW'(QUEUE_DEPTH))
  `ASSERT_IMP(a_wake_due, res_valid_q && (kind_q == KIND_WAKE), res_wake_q <= tick_q)

endmodule

// File: hw/rtl/sorted_sleep_wakeup_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_sleep_wakeup_queue_unit
// Tick counter with a bounded queue of sleepers kept sorted by wake tick.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// request   in         start_i & !busy_o          action_i, sleeper_id_i, duration_i
// result    out        res_valid_o (1-cycle strobe) kind_o, sleeper_id_res_o,
//                                                 wake_tick_o, last_o
//
// Sleep: a start state, then a read state and a compare state per queued entry
// examined, plus a write state when the new entry lands at the head.
// Tick: a read state and a compare state per entry examined, plus a flush state when the queue drains.
// Each result strobes in the cycle after it is decided; the receiver cannot stall.
// Reset clears the counter and fill count; entry memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_sleep_wakeup_queue_unit
  import ssq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_WIDTH    = IdWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [IdPortW-1:0] sleeper_id_i,
  input  logic [DurW-1:0]    duration_i,
  output logic               res_valid_o,
  output logic [KindW-1:0]   kind_o,
  output logic [IdPortW-1:0] sleeper_id_res_o,
  output logic [TickW-1:0]   wake_tick_o,
  output logic               last_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ssq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .busy_o   (busy_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ssq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sleeper_id_i     (sleeper_id_i),
    .duration_i       (duration_i),
    .res_valid_o      (res_valid_o),
    .kind_o           (kind_o),
    .sleeper_id_res_o (sleeper_id_res_o),
    .wake_tick_o      (wake_tick_o),
    .last_o           (last_o)
  );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of sorted_sleep_wakeup_queue_unit. A driver sends sleep and tick
// items in random bursts. A queue model predicts the accept, reject and wake
// results of each accepted item. A monitor checks every result strobe, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ssq_pkg::*;

  localparam int Depth      = QueueDepthDef;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 80;

  typedef struct {
    logic               action;
    logic [IdPortW-1:0] id;
    logic [DurW-1:0]    dur;
    logic               hold;
  } sleep_req_t;

  typedef struct {
    kind_e              kind;
    logic [IdPortW-1:0] id;
    logic [TickW-1:0]   wake;
    logic               last;
  } queue_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               action_i = ACT_SLEEP;
  logic [IdPortW-1:0] sleeper_id_i = '0;
  logic [DurW-1:0]    duration_i = '0;
  logic               res_valid_o;
  logic [KindW-1:0]   kind_o;
  logic [IdPortW-1:0] sleeper_id_res_o;
  logic [TickW-1:0]   wake_tick_o;
  logic               last_o;

  sleep_req_t req_backlog[$];
  queue_res_t due_results[$];

  // queue model
  logic [TickW-1:0]   tick_now;
  logic [TickW-1:0]   slot_wake[Depth];
  logic [IdPortW-1:0] slot_id[Depth];
  int                 slot_count;

  int   n_mismatch = 0;
  int   n_cycles = 0;
  logic taken_q = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  sorted_sleep_wakeup_queue_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .sleeper_id_i     (sleeper_id_i),
    .duration_i       (duration_i),
    .res_valid_o      (res_valid_o),
    .kind_o           (kind_o),
    .sleeper_id_res_o (sleeper_id_res_o),
    .wake_tick_o      (wake_tick_o),
    .last_o           (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic post_result(input kind_e k, input logic [IdPortW-1:0] id,
                             input logic [TickW-1:0] wk, input logic lst);
    queue_res_t r;
    r.kind = k;
    r.id   = id;
    r.wake = wk;
    r.last = lst;
    due_results.push_back(r);
  endtask

  task automatic advance_queue_model(input sleep_req_t r);
    logic [TickW-1:0]   wk;
    logic [IdPortW-1:0] id;
    int                 pos;
    int                 n;
    id = r.id & IdPortW'((1 << IdWidthDef) - 1);
    if (r.action == ACT_SLEEP) begin
      wk = tick_now + TickW'(r.dur);
      if (slot_count >= Depth) begin
        post_result(KIND_REJECT, id, wk, 1'b1);
      end else begin
        pos = 0;
        while (pos < slot_count && slot_wake[pos] <= wk) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_wake[i] = slot_wake[i-1];
          slot_id[i]   = slot_id[i-1];
        end
        slot_wake[pos] = wk;
        slot_id[pos]   = id;
        slot_count++;
        post_result(KIND_ACCEPT, id, wk, 1'b1);
      end
    end else begin
      tick_now = tick_now + 1;
      n = 0;
      while (n < slot_count && slot_wake[n] <= tick_now) begin
        post_result(KIND_WAKE, slot_id[n], slot_wake[n], 1'b0);
        n++;
      end
      if (n > 0) begin
        due_results[due_results.size()-1].last = 1'b1;
        for (int i = n; i < slot_count; i++) begin
          slot_wake[i-n] = slot_wake[i];
          slot_id[i-n]   = slot_id[i];
        end
        slot_count -= n;
      end
    end
  endtask

  task automatic add_req(input logic act, input logic [IdPortW-1:0] id,
                         input logic [DurW-1:0] dur, input logic hold);
    sleep_req_t r;
    r.action = act;
    r.id     = id;
    r.dur    = dur;
    r.hold   = hold;
    req_backlog.push_back(r);
  endtask

  // monitor and acceptance
  always @(posedge clk_i) begin : mon
    queue_res_t e;
    sleep_req_t r;
    n_cycles <= n_cycles + 1;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (due_results.size() == 0) begin
          $error("result with none due: kind %0d id %0d wake %0d", kind_o,
                 sleeper_id_res_o, wake_tick_o);
          n_mismatch++;
        end else begin
          e = due_results.pop_front();
          if (kind_o !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind_o);
            n_mismatch++;
          end
          if (sleeper_id_res_o !== e.id) begin
            $error("sleeper_id_res: expected %0d, got %0d", e.id, sleeper_id_res_o);
            n_mismatch++;
          end
          if (wake_tick_o !== e.wake) begin
            $error("wake_tick: expected %0d, got %0d", e.wake, wake_tick_o);
            n_mismatch++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            n_mismatch++;
          end
        end
      end
      if (start_i && !busy_o) begin
        r.action = action_i;
        r.id     = sleeper_id_i;
        r.dur    = duration_i;
        r.hold   = 1'b0;
        advance_queue_model(r);
      end
      taken_q <= start_i && !busy_o;
    end
  end

  // driver
  always @(negedge clk_i) begin : drv
    logic       nxt_start;
    sleep_req_t r;
    nxt_start = start_i;
    if (rst_ni && (!start_i || taken_q)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].hold && due_results.size() != 0)) begin
        r = req_backlog.pop_front();
        action_i     <= r.action;
        sleeper_id_i <= r.id;
        duration_i   <= r.dur;
        nxt_start = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(13, 30);
          endcase
        end
      end
    end
    start_i <= nxt_start;
  end

  always @(posedge clk_i) begin
    if (n_cycles > CycleLimit) begin
      $display("[sorted_sleep_wakeup_queue_unit] ERROR");
      $finish;
    end
  end

  initial begin : stim
    int          p;
    int          rr;
    sleep_req_t  r;
    tick_now   = '0;
    slot_count = 0;

    // directed part
    add_req(ACT_SLEEP, 8'h00, 32'd0, 1'b0);           // zero duration
    add_req(ACT_TICK,  8'h00, 32'd0, 1'b0);           // wakes it
    add_req(ACT_TICK,  8'hFF, 32'hFFFF_FFFF, 1'b0);   // wakes no one
    add_req(ACT_SLEEP, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_req(ACT_SLEEP, 8'hA5, 32'd3, 1'b0);
    add_req(ACT_SLEEP, 8'h5A, 32'd3, 1'b0);           // equal wake tick
    add_req(ACT_SLEEP, 8'h01, 32'd1, 1'b0);           // goes to head
    for (int i = 0; i < 12; i++) add_req(ACT_SLEEP, IdPortW'(8'h10 + i), 32'd2, 1'b0);
    add_req(ACT_SLEEP, 8'h77, 32'd0, 1'b0);           // queue full
    add_req(ACT_SLEEP, 8'h88, 32'd9, 1'b0);
    add_req(ACT_TICK,  8'h00, 32'd0, 1'b0);
    add_req(ACT_TICK,  8'h00, 32'd0, 1'b0);           // wakes twelve at once
    add_req(ACT_TICK,  8'h00, 32'd0, 1'b0);

    // random part
    for (int seg = 0; seg < 6; seg++) begin
      case ($urandom_range(0, 2))
        0: p = 30;
        1: p = 55;
        default: p = 85;
      endcase
      for (int k = 0; k < 26; k++) begin
        r.action = ($urandom_range(0, 99) < p) ? ACT_SLEEP : ACT_TICK;
        r.id     = IdPortW'($urandom_range(0, 255));
        rr = $urandom_range(0, 99);
        if (rr < 2) r.dur = $urandom();
        else if (rr < 12) r.dur = DurW'($urandom_range(0, 3));
        else r.dur = DurW'($urandom_range(0, 24));
        add_req(r.action, r.id, r.dur, (k == 0) && (seg == 0 || seg == 3));
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || start_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("[sorted_sleep_wakeup_queue_unit] OK");
    end else begin
      $display("[sorted_sleep_wakeup_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ssq_pkg.sv
hw/rtl/ssq_ctrl.sv
hw/rtl/ssq_datapath.sv
hw/rtl/sorted_sleep_wakeup_queue_unit.sv
verif/tb_top.sv
